// ===== rtl/core/cubic_root_solver_assert.svh =====
// Assertion macros for the cubic root solver.
// Used by the top level; expects clk and rst_n in scope.
`ifndef CUBIC_ROOT_SOLVER_ASSERT_SVH
`define CUBIC_ROOT_SOLVER_ASSERT_SVH
`define CRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define CRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/crs_pkg.sv =====
// Shared types and codes for the cubic root solver.
// No dependencies.
package crs_pkg;

  typedef logic [1:0] arith_op_t;
  localparam arith_op_t OP_MUL  = 2'd0;
  localparam arith_op_t OP_DIV  = 2'd1;
  localparam arith_op_t OP_SQRT = 2'd2;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_ctl_t;

  typedef struct packed {
    logic a_zero;
    logic b_zero;
  } coef_flags_t;

  localparam logic [2:0] STAT_REAL   = 3'd0;
  localparam logic [2:0] STAT_CPLX   = 3'd1;
  localparam logic [2:0] STAT_QUAD   = 3'd2;
  localparam logic [2:0] STAT_NOCONV = 3'd3;
  localparam logic [2:0] STAT_DEGEN  = 3'd4;

  localparam logic [1:0] REG_BOUND = 2'd0;
  localparam logic [1:0] REG_STEPS = 2'd1;
  localparam logic [1:0] REG_TOL   = 2'd2;

endpackage

// ===== rtl/core/crs_front.sv =====
// Input side: accepts coefficient items, flags zero leading terms, queues them.
// Depends on crs_pkg.
module crs_front import crs_pkg::*; #(
  parameter int W = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [4*W-1:0]    in_data,
  output logic              q_valid,
  output logic [4*W-1:0]    q_data,
  output coef_flags_t       q_flags,
  input  logic              q_pop
);

  logic [4*W-1:0] ent_r [2];
  coef_flags_t    flg_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           wr, rd;
  coef_flags_t    flg_in;

  assign in_tready = (cnt_r != 2'd2);
  assign wr        = in_tvalid && in_tready;
  assign rd        = q_pop && q_valid;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_data    = ent_r[rp_r];
  assign q_flags   = flg_r[rp_r];

  always_comb begin
    flg_in.a_zero = (in_data[W-1:0] == '0);
    flg_in.b_zero = (in_data[2*W-1:W] == '0);
    wp_nxt  = wr ? ~wp_r : wp_r;
    rp_nxt  = rd ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, wr} - {1'b0, rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      ent_r[wp_r] <= in_data;
      flg_r[wp_r] <= flg_in;
    end
  end

endmodule

// ===== rtl/core/crs_arith.sv =====
// Shared multi-cycle arithmetic: saturating fixed-point multiply (four partial
// products), restoring divide and square root, one bit per cycle. Uses crs_pkg.
module crs_arith import crs_pkg::*; #(
  parameter int W = 48,
  parameter int F = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  arith_ctl_t          ctl,
  input  logic signed [W-1:0] opa,
  input  logic signed [W-1:0] opb,
  output logic                done,
  output logic signed [W-1:0] res
);

  localparam int H  = (W + 1) / 2;
  localparam int DW = W + F;
  localparam int RW = DW + (DW % 2);
  localparam int RB = RW / 2;
  localparam int MW = (2 * W > DW) ? 2 * W : DW;
  localparam int CW = $clog2(RW + 1);

  localparam logic [2:0] A_IDLE = 3'd0;
  localparam logic [2:0] A_MUL  = 3'd1;
  localparam logic [2:0] A_DIV  = 3'd2;
  localparam logic [2:0] A_SQRT = 3'd3;
  localparam logic [2:0] A_FIN  = 3'd4;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [MW-1:0] VMAX_M = MW'(VMAX);

  logic [2:0]      st_r, st_nxt;
  logic [W-1:0]    ma_r, ma_nxt, mb_r, mb_nxt;
  logic [2*W-1:0]  acc_r, acc_nxt;
  logic [1:0]      ph_r, ph_nxt;
  logic            neg_r, neg_nxt;
  logic [MW-1:0]   fm_r, fm_nxt;
  logic [RW-1:0]   sh_r, sh_nxt;
  logic [W:0]      rem_r, rem_nxt;
  logic [DW-1:0]   q_r, q_nxt;
  logic [RB:0]     srem_r, srem_nxt;
  logic [RB-1:0]   root_r, root_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            done_r, done_nxt;
  logic signed [W-1:0] res_r, res_nxt;

  logic [W-1:0]    mag_a, mag_b;
  logic [H-1:0]    pa, pb;
  logic [2*H-1:0]  pp;
  logic [2*W-1:0]  pp_sh;
  logic [W:0]      dt;
  logic            dge;
  logic [RB+2:0]   st_t, st_trial;
  logic            sge;

  assign done = done_r;
  assign res  = res_r;

  always_comb begin
    mag_a = opa[W-1] ? W'(-opa) : W'(opa);
    mag_b = opb[W-1] ? W'(-opb) : W'(opb);
    pa    = ph_r[0] ? H'(ma_r[W-1:H]) : ma_r[H-1:0];
    pb    = ph_r[1] ? H'(mb_r[W-1:H]) : mb_r[H-1:0];
    pp    = pa * pb;
    unique case (ph_r)
      2'd0:    pp_sh = (2*W)'(pp);
      2'd3:    pp_sh = (2*W)'(pp) << (2 * H);
      default: pp_sh = (2*W)'(pp) << H;
    endcase
    dt       = {rem_r[W-1:0], sh_r[DW-1]};
    dge      = (dt >= {1'b0, ma_r});
    st_t     = {srem_r, sh_r[RW-1:RW-2]};
    st_trial = (RB+3)'({root_r, 2'b01});
    sge      = (st_t >= st_trial);
  end

  always_comb begin
    st_nxt   = st_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    ph_nxt   = ph_r;
    neg_nxt  = neg_r;
    fm_nxt   = fm_r;
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    srem_nxt = srem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    unique case (st_r)
      A_IDLE: begin
        if (ctl.start) begin
          cnt_nxt = '0;
          unique case (ctl.op)
            OP_MUL: begin
              ma_nxt  = mag_a;
              mb_nxt  = mag_b;
              neg_nxt = opa[W-1] ^ opb[W-1];
              acc_nxt = '0;
              ph_nxt  = 2'd0;
              st_nxt  = A_MUL;
            end
            OP_DIV: begin
              neg_nxt = opa[W-1] ^ opb[W-1];
              if (opa == '0) begin
                fm_nxt  = '0;
                st_nxt  = A_FIN;
              end else if (opb == '0) begin
                neg_nxt = opa[W-1];
                fm_nxt  = '1;
                st_nxt  = A_FIN;
              end else begin
                sh_nxt  = RW'({mag_a, {F{1'b0}}});
                ma_nxt  = mag_b;
                rem_nxt = '0;
                q_nxt   = '0;
                st_nxt  = A_DIV;
              end
            end
            OP_SQRT: begin
              neg_nxt = 1'b0;
              if (opa[W-1] || opa == '0) begin
                fm_nxt = '0;
                st_nxt = A_FIN;
              end else begin
                sh_nxt   = RW'({opa, {F{1'b0}}});
                srem_nxt = '0;
                root_nxt = '0;
                st_nxt   = A_SQRT;
              end
            end
            default: st_nxt = A_IDLE;
          endcase
        end
      end
      A_MUL: begin
        acc_nxt = acc_r + pp_sh;
        ph_nxt  = ph_r + 2'd1;
        if (ph_r == 2'd3) begin
          fm_nxt = MW'(acc_nxt >> F);
          st_nxt = A_FIN;
        end
      end
      A_DIV: begin
        rem_nxt = dge ? dt - {1'b0, ma_r} : dt;
        q_nxt   = {q_r[DW-2:0], dge};
        sh_nxt  = sh_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          fm_nxt = MW'(q_nxt);
          st_nxt = A_FIN;
        end
      end
      A_SQRT: begin
        srem_nxt = sge ? (RB+1)'(st_t - st_trial) : (RB+1)'(st_t);
        root_nxt = {root_r[RB-2:0], sge};
        sh_nxt   = sh_r << 2;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(RB - 1)) begin
          fm_nxt = MW'(root_nxt);
          st_nxt = A_FIN;
        end
      end
      A_FIN: begin
        if (neg_r) begin
          res_nxt = (fm_r > VMAX_M + MW'(1)) ? VMIN : -$signed(fm_r[W-1:0]);
        end else begin
          res_nxt = (fm_r > VMAX_M) ? VMAX : $signed(fm_r[W-1:0]);
        end
        done_nxt = 1'b1;
        st_nxt   = A_IDLE;
      end
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    acc_r  <= acc_nxt;
    ph_r   <= ph_nxt;
    neg_r  <= neg_nxt;
    fm_r   <= fm_nxt;
    sh_r   <= sh_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    srem_r <= srem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ===== rtl/core/crs_engine.sv =====
// Back end sequencer: bisection, Newton refinement, deflation and result
// register. Issues all multiplies, divides and roots to crs_arith. Uses crs_pkg.
module crs_engine import crs_pkg::*; #(
  parameter int W = 48,
  parameter int F = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  logic [4*W-1:0]      q_data,
  input  coef_flags_t         q_flags,
  output logic                q_pop,
  input  logic [15:0]         bound,
  input  logic [6:0]          max_steps,
  input  logic [32:0]         tol,
  output arith_ctl_t          ar_ctl,
  output logic signed [W-1:0] ar_a,
  output logic signed [W-1:0] ar_b,
  input  logic                ar_done,
  input  logic signed [W-1:0] ar_res,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [W-1:0]        out_r1,
  output logic [W-1:0]        out_r2,
  output logic [W-1:0]        out_r3,
  output logic [W-2:0]        out_im,
  output logic [2:0]          out_stat,
  output logic [6:0]          out_iter
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BIS   = 5'd1;
  localparam logic [4:0] S_BIS_L = 5'd2;
  localparam logic [4:0] S_BIS_M = 5'd3;
  localparam logic [4:0] S_P0    = 5'd4;
  localparam logic [4:0] S_P1    = 5'd5;
  localparam logic [4:0] S_P2    = 5'd6;
  localparam logic [4:0] S_P3    = 5'd7;
  localparam logic [4:0] S_WAIT  = 5'd8;
  localparam logic [4:0] S_NWT   = 5'd9;
  localparam logic [4:0] S_NWT_D = 5'd10;
  localparam logic [4:0] S_D1    = 5'd11;
  localparam logic [4:0] S_D2    = 5'd12;
  localparam logic [4:0] S_NWT_U = 5'd13;
  localparam logic [4:0] S_FIN0  = 5'd14;
  localparam logic [4:0] S_Q1    = 5'd15;
  localparam logic [4:0] S_F1    = 5'd16;
  localparam logic [4:0] S_F2    = 5'd17;
  localparam logic [4:0] S_F3    = 5'd18;
  localparam logic [4:0] S_F4    = 5'd19;
  localparam logic [4:0] S_F5    = 5'd20;
  localparam logic [4:0] S_RR    = 5'd21;
  localparam logic [4:0] S_CC    = 5'd22;
  localparam logic [4:0] S_OUT   = 5'd23;

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam int BW = (16 + F + 1 > W + 1) ? 16 + F + 1 : W + 1;
  localparam int TW = (W > 33) ? W : 33;
  localparam logic [W:0] QUARTER = (W+1)'(1) << (F - 2);

  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] x,
                                               input logic signed [W-1:0] y);
    logic signed [W:0] s;
    s = {x[W-1], x} + {y[W-1], y};
    if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
    return s[W-1:0];
  endfunction

  function automatic logic signed [W-1:0] sneg(input logic signed [W-1:0] x);
    return (x == VMIN) ? VMAX : -x;
  endfunction

  function automatic logic signed [W-1:0] half(input logic signed [W-1:0] x);
    logic signed [W-1:0] h;
    h = x >>> 1;
    if (x[W-1] && x[0]) h = h + W'(1);
    return h;
  endfunction

  logic [4:0] st_r, st_nxt, wret_r, wret_nxt, pret_r, pret_nxt;
  logic signed [W-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic signed [W-1:0] a3_r, a3_nxt, b2_r, b2_nxt;
  logic signed [W-1:0] lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt, fl_r, fl_nxt;
  logic signed [W-1:0] px_r, px_nxt, pv_r, pv_nxt, pr_r, pr_nxt, fx_r, fx_nxt;
  logic signed [W-1:0] x_r, x_nxt, bb_r, bb_nxt, t_r, t_nxt, c2_r, c2_nxt;
  logic signed [W-1:0] dl_r, dl_nxt, r2_r, r2_nxt, r3_r, r3_nxt;
  logic [W-2:0]        im_r, im_nxt;
  logic                az_r, az_nxt, bz_r, bz_nxt, conv_r, conv_nxt;
  logic [6:0]          steps_r, steps_nxt, cnt_r, cnt_nxt;
  logic [2:0]          stat_r, stat_nxt;
  logic                ov_r, ov_nxt;
  logic [W-1:0]        o1_r, o1_nxt, o2_r, o2_nxt, o3_r, o3_nxt;
  logic [W-2:0]        oi_r, oi_nxt;
  logic [2:0]          os_r, os_nxt;
  logic [6:0]          on_r, on_nxt;

  logic [BW-1:0]       bq;
  logic signed [W-1:0] hi0, ca, cb, cc, cd, ytmp, mtmp, nb;
  logic signed [W:0]   diff;
  logic [W-1:0]        magm;
  logic [6:0]          limit, cnt_inc;

  assign out_valid = ov_r;
  assign out_r1    = o1_r;
  assign out_r2    = o2_r;
  assign out_r3    = o3_r;
  assign out_im    = oi_r;
  assign out_stat  = os_r;
  assign out_iter  = on_r;
  assign q_pop     = (st_r == S_IDLE) && q_valid;

  always_comb begin
    ca      = q_data[W-1:0];
    cb      = q_data[2*W-1:W];
    cc      = q_data[3*W-1:2*W];
    cd      = q_data[4*W-1:3*W];
    bq      = BW'(bound) << F;
    hi0     = (bq > BW'(VMAX)) ? VMAX : bq[W-1:0];
    diff    = {hi_r[W-1], hi_r} - {lo_r[W-1], lo_r};
    limit   = (max_steps == '0) ? 7'd1 : max_steps;
    cnt_inc = (cnt_r == 7'd127) ? cnt_r : cnt_r + 7'd1;
    magm    = pr_r[W-1] ? W'(-pr_r) : W'(pr_r);
    nb      = sneg(bb_r);
    ytmp    = '0;
    mtmp    = '0;

    st_nxt = st_r;  wret_nxt = wret_r;  pret_nxt = pret_r;
    a_nxt = a_r;  b_nxt = b_r;  c_nxt = c_r;  d_nxt = d_r;
    a3_nxt = a3_r;  b2_nxt = b2_r;  az_nxt = az_r;  bz_nxt = bz_r;
    lo_nxt = lo_r;  hi_nxt = hi_r;  mid_nxt = mid_r;  fl_nxt = fl_r;
    px_nxt = px_r;  pv_nxt = pv_r;  pr_nxt = pr_r;  fx_nxt = fx_r;
    x_nxt = x_r;  bb_nxt = bb_r;  t_nxt = t_r;  c2_nxt = c2_r;  dl_nxt = dl_r;
    r2_nxt = r2_r;  r3_nxt = r3_r;  im_nxt = im_r;  stat_nxt = stat_r;
    conv_nxt = conv_r;  steps_nxt = steps_r;  cnt_nxt = cnt_r;
    ov_nxt = ov_r && !out_ready;
    o1_nxt = o1_r;  o2_nxt = o2_r;  o3_nxt = o3_r;  oi_nxt = oi_r;
    os_nxt = os_r;  on_nxt = on_r;
    ar_ctl.start = 1'b0;
    ar_ctl.op    = OP_MUL;
    ar_a         = '0;
    ar_b         = '0;

    unique case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          a_nxt  = ca;  b_nxt = cb;  c_nxt = cc;  d_nxt = cd;
          az_nxt = q_flags.a_zero;
          bz_nxt = q_flags.b_zero;
          a3_nxt = sadd(sadd(ca, ca), ca);
          b2_nxt = sadd(cb, cb);
          hi_nxt = hi0;
          lo_nxt = -hi0;
          cnt_nxt = '0;
          st_nxt = S_BIS;
        end
      end
      S_BIS: begin
        if (diff >= QUARTER) begin
          mid_nxt  = W'({lo_r[W-1], lo_r} + (diff >>> 1));
          px_nxt   = lo_r;
          pret_nxt = S_BIS_L;
          st_nxt   = S_P0;
        end else begin
          x_nxt     = W'({lo_r[W-1], lo_r} + (diff >>> 1));
          steps_nxt = '0;
          st_nxt    = S_NWT;
        end
      end
      S_BIS_L: begin
        fl_nxt   = pv_r;
        px_nxt   = mid_r;
        pret_nxt = S_BIS_M;
        st_nxt   = S_P0;
      end
      S_BIS_M: begin
        if ((fl_r <= 0 && pv_r >= 0) || (fl_r >= 0 && pv_r <= 0)) hi_nxt = mid_r;
        else lo_nxt = mid_r;
        cnt_nxt = cnt_inc;
        st_nxt  = S_BIS;
      end
      S_P0: begin
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_MUL;  ar_a = a_r;  ar_b = px_r;
        wret_nxt = S_P1;  st_nxt = S_WAIT;
      end
      S_P1: begin
        ytmp = sadd(pr_r, b_r);
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_MUL;  ar_a = px_r;  ar_b = ytmp;
        wret_nxt = S_P2;  st_nxt = S_WAIT;
      end
      S_P2: begin
        ytmp = sadd(pr_r, c_r);
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_MUL;  ar_a = px_r;  ar_b = ytmp;
        wret_nxt = S_P3;  st_nxt = S_WAIT;
      end
      S_P3: begin
        pv_nxt = sadd(pr_r, d_r);
        st_nxt = pret_r;
      end
      S_WAIT: begin
        if (ar_done) begin
          pr_nxt = ar_res;
          st_nxt = wret_r;
        end
      end
      S_NWT: begin
        px_nxt   = x_r;
        pret_nxt = S_NWT_D;
        st_nxt   = S_P0;
      end
      S_NWT_D: begin
        fx_nxt = pv_r;
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_MUL;  ar_a = a3_r;  ar_b = x_r;
        wret_nxt = S_D1;  st_nxt = S_WAIT;
      end
      S_D1: begin
        ytmp = sadd(pr_r, b2_r);
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_MUL;  ar_a = x_r;  ar_b = ytmp;
        wret_nxt = S_D2;  st_nxt = S_WAIT;
      end
      S_D2: begin
        ytmp = sadd(pr_r, c_r);
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_DIV;  ar_a = fx_r;  ar_b = ytmp;
        wret_nxt = S_NWT_U;  st_nxt = S_WAIT;
      end
      S_NWT_U: begin
        x_nxt     = sadd(x_r, sneg(pr_r));
        steps_nxt = steps_r + 7'd1;
        cnt_nxt   = cnt_inc;
        conv_nxt  = (TW'(magm) < TW'(tol));
        if (!conv_nxt && steps_nxt < limit) st_nxt = S_NWT;
        else st_nxt = S_FIN0;
      end
      S_FIN0: begin
        r2_nxt = '0;  r3_nxt = '0;  im_nxt = '0;
        if (!az_r) begin
          ar_ctl.start = 1'b1;  ar_ctl.op = OP_DIV;  ar_a = b_r;  ar_b = a_r;
          wret_nxt = S_F1;  st_nxt = S_WAIT;
        end else if (!bz_r) begin
          ar_ctl.start = 1'b1;  ar_ctl.op = OP_DIV;  ar_a = c_r;  ar_b = b_r;
          wret_nxt = S_Q1;  st_nxt = S_WAIT;
        end else begin
          stat_nxt = STAT_DEGEN;
          st_nxt   = S_OUT;
        end
      end
      S_Q1: begin
        r2_nxt   = sneg(sadd(pr_r, x_r));
        stat_nxt = STAT_QUAD;
        st_nxt   = S_OUT;
      end
      S_F1: begin
        bb_nxt = sadd(pr_r, x_r);
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_DIV;  ar_a = c_r;  ar_b = a_r;
        wret_nxt = S_F2;  st_nxt = S_WAIT;
      end
      S_F2: begin
        t_nxt = pr_r;
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_MUL;  ar_a = x_r;  ar_b = bb_r;
        wret_nxt = S_F3;  st_nxt = S_WAIT;
      end
      S_F3: begin
        mtmp   = sadd(t_r, pr_r);
        c2_nxt = sadd(mtmp, mtmp);
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_MUL;  ar_a = bb_r;  ar_b = bb_r;
        wret_nxt = S_F4;  st_nxt = S_WAIT;
      end
      S_F4: begin
        dl_nxt = sadd(pr_r, sneg(sadd(c2_r, c2_r)));
        st_nxt = S_F5;
      end
      S_F5: begin
        ar_ctl.start = 1'b1;  ar_ctl.op = OP_SQRT;
        ar_a = dl_r[W-1] ? sneg(dl_r) : dl_r;
        wret_nxt = dl_r[W-1] ? S_CC : S_RR;
        st_nxt   = S_WAIT;
      end
      S_RR: begin
        r2_nxt   = half(sadd(nb, pr_r));
        r3_nxt   = half(sadd(nb, sneg(pr_r)));
        stat_nxt = STAT_REAL;
        st_nxt   = S_OUT;
      end
      S_CC: begin
        r2_nxt   = half(nb);
        r3_nxt   = half(nb);
        im_nxt   = pr_r[W-1:1];
        stat_nxt = STAT_CPLX;
        st_nxt   = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          o1_nxt = x_r;
          o2_nxt = r2_r;
          o3_nxt = r3_r;
          oi_nxt = im_r;
          os_nxt = (!conv_r && stat_r != STAT_DEGEN) ? STAT_NOCONV : stat_r;
          on_nxt = cnt_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wret_r <= wret_nxt;  pret_r <= pret_nxt;
    a_r <= a_nxt;  b_r <= b_nxt;  c_r <= c_nxt;  d_r <= d_nxt;
    a3_r <= a3_nxt;  b2_r <= b2_nxt;  az_r <= az_nxt;  bz_r <= bz_nxt;
    lo_r <= lo_nxt;  hi_r <= hi_nxt;  mid_r <= mid_nxt;  fl_r <= fl_nxt;
    px_r <= px_nxt;  pv_r <= pv_nxt;  pr_r <= pr_nxt;  fx_r <= fx_nxt;
    x_r <= x_nxt;  bb_r <= bb_nxt;  t_r <= t_nxt;  c2_r <= c2_nxt;  dl_r <= dl_nxt;
    r2_r <= r2_nxt;  r3_r <= r3_nxt;  im_r <= im_nxt;  stat_r <= stat_nxt;
    conv_r <= conv_nxt;  steps_r <= steps_nxt;  cnt_r <= cnt_nxt;
    o1_r <= o1_nxt;  o2_r <= o2_nxt;  o3_r <= o3_nxt;  oi_r <= oi_nxt;
    os_r <= os_nxt;  on_r <= on_nxt;
  end

endmodule

// ===== rtl/core/cubic_root_solver.sv =====
// Cubic root solver top level: config registers, front queue, sequencer, arith unit.
// Depends on crs_pkg, crs_front, crs_arith, crs_engine, cubic_root_solver_assert.svh.
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata: coef_a, coef_b, coef_c, coef_d
//  out_    | master    | out_tvalid/out_tready| out_tdata: roots, imag, iterations; tuser: status
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One item at a time in the sequencer; a two-item queue takes new items meanwhile.
// Reset is synchronous; no clearing pass. Output held in a register while out_tready is low.
module cubic_root_solver import crs_pkg::*; #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // coef_a, coef_b, coef_c, coef_d, zero pad
  input  logic [((4*WORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // first_root, second_root, third_root, imag_part, iterations, zero pad
  output logic [((4*WORD_BITS+6+7)/8)*8-1:0] out_tdata,
  // status
  output logic [2:0]            out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [32:0]           cfg_data
);

  localparam int W  = WORD_BITS;
  localparam int OW = ((4*WORD_BITS+6+7)/8)*8;

  logic [15:0] bound_r;
  logic [6:0]  steps_r;
  logic [32:0] tol_r;

  logic                q_valid, q_pop;
  logic [4*W-1:0]      q_data;
  coef_flags_t         q_flags;
  arith_ctl_t          ar_ctl;
  logic signed [W-1:0] ar_a, ar_b, ar_res;
  logic                ar_done;
  logic [W-1:0]        r1, r2, r3;
  logic [W-2:0]        im;
  logic [2:0]          stat;
  logic [6:0]          iter;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_r <= 16'd64;
      steps_r <= 7'd32;
      tol_r   <= 33'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOUND: bound_r <= cfg_data[15:0];
        REG_STEPS: steps_r <= cfg_data[6:0];
        REG_TOL:   tol_r   <= cfg_data;
        default:   ;
      endcase
    end
  end

  crs_front #(.W(W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_data   (in_tdata[4*W-1:0]),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_flags   (q_flags),
    .q_pop     (q_pop)
  );

  crs_arith #(.W(W), .F(FRAC_BITS)) u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ar_ctl),
    .opa   (ar_a),
    .opb   (ar_b),
    .done  (ar_done),
    .res   (ar_res)
  );

  crs_engine #(.W(W), .F(FRAC_BITS)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_flags   (q_flags),
    .q_pop     (q_pop),
    .bound     (bound_r),
    .max_steps (steps_r),
    .tol       (tol_r),
    .ar_ctl    (ar_ctl),
    .ar_a      (ar_a),
    .ar_b      (ar_b),
    .ar_done   (ar_done),
    .ar_res    (ar_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_r1    (r1),
    .out_r2    (r2),
    .out_r3    (r3),
    .out_im    (im),
    .out_stat  (stat),
    .out_iter  (iter)
  );

  assign out_tdata = OW'({iter, im, r3, r2, r1});
  assign out_tuser = stat;

`include "cubic_root_solver_assert.svh"

  `CRS_ASSERT_NOW(a_quad_zero, out_tvalid && (stat == STAT_QUAD || stat == STAT_DEGEN), r3 == '0 && im == '0, "nonzero third root or imag")
  `CRS_ASSERT_NOW(a_real_imag, out_tvalid && stat == STAT_REAL, im == '0, "real roots with imag")
  `CRS_ASSERT_NXT(a_cfg_bound, cfg_valid && cfg_ready && cfg_index == REG_BOUND, bound_r == $past(cfg_data[15:0]), "bound write lost")

endmodule
